// File: rtl/core/cswstr_pkg.sv
// Package for the C source comment and whitespace stripper.
// Holds the transfer types, character constants, scan state and the per-byte judge function.
// No dependencies.
package cswstr_pkg;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_present;
        logic       stream_end;
    } t_out_item;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_LINE   = 2'd1,
        MODE_BLOCK  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] prior;
        logic [7:0] last_emit;
        logic       in_str;
        t_mode      mode;
        logic [7:0] before_cmt;
    } t_scan;

    typedef struct packed {
        t_scan      st;
        logic       emit;
        logic [7:0] ch;
    } t_jres;

    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  d0;
        t_out_item  d1;
    } t_push;

    localparam t_scan SCAN_RESET = '{
        prior: 8'h00, last_emit: 8'h00, in_str: 1'b0, mode: MODE_NORMAL, before_cmt: 8'h00
    };

    localparam logic [8:0] C_NONE  = 9'h100;
    localparam logic [8:0] C_US    = 9'h05F;
    localparam logic [8:0] C_DOLL  = 9'h024;
    localparam logic [8:0] C_DQ    = 9'h022;
    localparam logic [8:0] C_SQ    = 9'h027;
    localparam logic [8:0] C_BSL   = 9'h05C;
    localparam logic [8:0] C_SLASH = 9'h02F;
    localparam logic [8:0] C_STAR  = 9'h02A;
    localparam logic [8:0] C_NL    = 9'h00A;
    localparam logic [8:0] C_SP    = 9'h020;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    function automatic logic is_space(logic [8:0] v);
        return (v == C_SP) || (v >= 9'h009 && v <= 9'h00D);
    endfunction

    function automatic logic is_alnum(logic [8:0] v);
        return (v >= 9'h030 && v <= 9'h039) || (v >= 9'h061 && v <= 9'h07A)
            || (v >= 9'h041 && v <= 9'h05A);
    endfunction

    function automatic logic is_ident(logic [8:0] v);
        return is_alnum(v) || (v == C_US) || (v == C_DOLL);
    endfunction

    function automatic logic is_sep(logic [8:0] v);
        logic punct;
        punct = (v >= 9'h021) && (v <= 9'h07E) && !is_alnum(v);
        return is_space(v) || (punct && (v != C_US) && (v != C_DOLL));
    endfunction

    function automatic t_jres judge(t_scan st, logic [8:0] c, logic [8:0] n);
        t_jres      r;
        logic [8:0] p;
        logic       in_s;
        logic       keep;
        r      = '0;
        r.st   = st;
        r.emit = 1'b0;
        r.ch   = c[7:0];
        p      = {1'b0, st.prior};
        in_s   = st.in_str;
        keep   = 1'b1;
        unique case (st.mode)
            MODE_LINE: begin
                if (n == C_NL) begin
                    r.st.mode  = MODE_NORMAL;
                    r.st.prior = st.before_cmt;
                end
            end
            MODE_BLOCK: begin
                if (c == C_SLASH && p == C_STAR) begin
                    r.st.mode = MODE_NORMAL;
                    if (is_ident({1'b0, st.before_cmt}) && is_ident(n)) begin
                        r.st.prior = C_SP[7:0];
                        r.emit     = 1'b1;
                        r.ch       = C_SP[7:0];
                    end else begin
                        r.st.prior = st.before_cmt;
                    end
                end else begin
                    r.st.prior = c[7:0];
                end
            end
            default: begin
                if (c == C_DQ) begin
                    if (in_s) begin
                        if (p != C_BSL) in_s = 1'b0;
                    end else if (!(p == C_SQ && n == C_SQ)) begin
                        in_s = 1'b1;
                    end
                end
                r.st.in_str = in_s;
                if (!in_s) begin
                    if (c == C_SLASH && (n == C_SLASH || n == C_STAR)) begin
                        r.st.before_cmt = p[7:0];
                        r.st.mode       = (n == C_SLASH) ? MODE_LINE : MODE_BLOCK;
                        r.st.prior      = c[7:0];
                        keep            = 1'b0;
                    end else if (is_space(c)
                                 && !(is_ident({1'b0, st.last_emit}) && is_ident(n))) begin
                        if ((c != C_NL && (is_sep(p) || is_sep(n))) || p == c || c == n)
                            keep = 1'b0;
                    end
                end
                if (keep) begin
                    r.st.last_emit = c[7:0];
                    r.st.prior     = c[7:0];
                    r.emit         = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/cswstr_scan.sv
// Input register, lookahead byte, scan state and per-byte decisions.
// Depends on cswstr_pkg; pushes up to two result transfers per item into the output queue.
module cswstr_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cswstr_pkg::t_in_item i_in_data,
    input  logic                 i_room,
    output cswstr_pkg::t_push    o_push
);

    logic                 r_in_valid;
    cswstr_pkg::t_in_item r_in;
    logic [7:0]           r_held;
    logic                 r_held_valid;
    cswstr_pkg::t_scan    r_st;

    cswstr_pkg::t_scan    n_st;
    logic [7:0]           n_held;
    logic                 n_held_valid;

    cswstr_pkg::t_jres    j1;
    cswstr_pkg::t_jres    j2;
    cswstr_pkg::t_scan    s_mid;
    cswstr_pkg::t_out_item head;
    cswstr_pkg::t_out_item tail;
    logic                 em0;
    logic                 fire;

    assign fire       = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;

    always_comb begin
        j1    = cswstr_pkg::judge(r_st, {1'b0, r_held}, {1'b0, r_in.in_char});
        s_mid = r_held_valid ? j1.st : r_st;
        em0   = r_held_valid && j1.emit;
        j2    = cswstr_pkg::judge(s_mid, {1'b0, r_in.in_char}, cswstr_pkg::C_NONE);

        head.out_char     = j1.ch;
        head.char_present = 1'b1;
        head.stream_end   = 1'b0;
        tail.out_char     = j2.emit ? j2.ch : 8'h00;
        tail.char_present = j2.emit;
        tail.stream_end   = 1'b1;

        o_push.d1 = tail;
        if (r_in.in_last) begin
            o_push.cnt = em0 ? 2'd2 : 2'd1;
            o_push.d0  = em0 ? head : tail;
        end else begin
            o_push.cnt = em0 ? 2'd1 : 2'd0;
            o_push.d0  = head;
        end
        if (!fire) o_push.cnt = 2'd0;
    end

    always_comb begin
        n_st         = r_st;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        if (fire) begin
            if (r_in.in_last) begin
                n_st         = cswstr_pkg::SCAN_RESET;
                n_held       = 8'h00;
                n_held_valid = 1'b0;
            end else begin
                n_st         = s_mid;
                n_held       = r_in.in_char;
                n_held_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_held       <= 8'h00;
            r_held_valid <= 1'b0;
            r_st         <= cswstr_pkg::SCAN_RESET;
        end else begin
            if (!r_in_valid || fire) r_in_valid <= i_in_valid;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_st         <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_in_valid || fire) r_in <= i_in_data;
    end

endmodule

// File: rtl/core/cswstr_outq.sv
// Four-entry result queue taking up to two transfers per cycle and giving one per cycle unless i_out_stall is high.
// Depends on cswstr_pkg.
module cswstr_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cswstr_pkg::t_push     i_push,
    output logic                  o_room,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cswstr_pkg::t_out_item o_out_data
);

    cswstr_pkg::t_out_item         r_mem [cswstr_pkg::QDEPTH];
    logic [cswstr_pkg::QAW-1:0]    r_wp;
    logic [cswstr_pkg::QAW-1:0]    r_rp;
    logic [cswstr_pkg::QCW-1:0]    r_count;
    logic [cswstr_pkg::QCW-1:0]    n_count;
    logic                          deq;

    localparam logic [cswstr_pkg::QCW-1:0] ROOM_MAX = cswstr_pkg::QCW'(cswstr_pkg::QDEPTH - 2);

    assign deq         = (r_count != '0) && !i_out_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rp];
    assign o_room      = (r_count <= ROOM_MAX);
    assign n_count     = r_count + cswstr_pkg::QCW'(i_push.cnt) - cswstr_pkg::QCW'(deq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + cswstr_pkg::QAW'(i_push.cnt);
            r_rp    <= r_rp + cswstr_pkg::QAW'(deq);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wp] <= i_push.d0;
        if (i_push.cnt == 2'd2) r_mem[r_wp + cswstr_pkg::QAW'(1)] <= i_push.d1;
    end

endmodule

// File: rtl/core/c_source_comment_whitespace_stripper_top.sv
// Minifies a C/C++ source byte stream: drops comments and redundant whitespace.
// One byte is accepted per cycle unless the input stalls; one result transfer leaves per cycle
// unless i_out_stall is high. A byte is judged once its successor is in the input register,
// and its result goes through a four-entry result queue. The last byte of a stream can cause two
// transfers; the final one carries stream_end, with char_present low for a bare end marker.
// The input stalls only when the result queue holds more than two entries.
// Depends on cswstr_pkg, cswstr_scan and cswstr_outq.
module c_source_comment_whitespace_stripper_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cswstr_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cswstr_pkg::t_out_item o_out_data
);

    cswstr_pkg::t_push push;
    logic              room;

    cswstr_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_room     (room),
        .o_push     (push)
    );

    cswstr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/sv/tb_c_source_comment_whitespace_stripper_top.sv
// Testbench for c_source_comment_whitespace_stripper_top: drives C-like byte streams and
// checks each result transfer against a built-in minifier prediction.
// Depends on cswstr_pkg and the top-level block.
`timescale 1ns / 100ps

module tb_c_source_comment_whitespace_stripper_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        cswstr_pkg::t_in_item d;
        int unsigned          gap;
        bit                   drain;
    } t_src_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    cswstr_pkg::t_in_item  in_data = '0;
    logic                  out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    cswstr_pkg::t_out_item o_out_data;

    t_src_item             source_q[$];
    cswstr_pkg::t_out_item stripped_q[$];
    logic [7:0]            text_q[$];

    logic [7:0]        hold_ch;
    logic              hold_ok;
    logic [7:0]        prev_ch;
    logic [7:0]        last_out;
    logic              in_quote;
    cswstr_pkg::t_mode scan;
    logic [7:0]        pre_cmt;

    int  errors = 0;
    int  bytes_sent = 0;
    int  results_seen = 0;
    int  streams_seen = 0;
    int  bare_seen = 0;
    int  idle_left = 0;
    int  stall_left = 0;
    int  free_left = 0;
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;
    int  gap_style = 0;
    t_src_item nxt;

    string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_$";
    string punct_chars = "+-*=;(){}[],<>&|!%^~?:.#/@";

    c_source_comment_whitespace_stripper_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit is_blank(input logic [8:0] v);
        return (v == cswstr_pkg::C_SP) || (v >= 9'h009 && v <= 9'h00D);
    endfunction

    function automatic bit is_alnum_ch(input logic [8:0] v);
        return (v >= "0" && v <= "9") || (v >= "a" && v <= "z") || (v >= "A" && v <= "Z");
    endfunction

    function automatic bit is_word(input logic [8:0] v);
        return is_alnum_ch(v) || v == cswstr_pkg::C_US || v == cswstr_pkg::C_DOLL;
    endfunction

    function automatic bit is_break(input logic [8:0] v);
        return is_blank(v) || (v >= 9'h021 && v <= 9'h07E && !is_alnum_ch(v)
                               && v != cswstr_pkg::C_US && v != cswstr_pkg::C_DOLL);
    endfunction

    task automatic clear_scan();
        hold_ch  = 8'h00;
        hold_ok  = 1'b0;
        prev_ch  = 8'h00;
        last_out = 8'h00;
        in_quote = 1'b0;
        scan     = cswstr_pkg::MODE_NORMAL;
        pre_cmt  = 8'h00;
    endtask

    // judge byte c with successor n (C_NONE at stream end); 1 if a byte is kept
    function automatic bit judge_char(input logic [8:0] c, input logic [8:0] n,
                                      output logic [7:0] ch);
        logic [8:0] p;
        p  = {1'b0, prev_ch};
        ch = c[7:0];
        if (scan == cswstr_pkg::MODE_LINE) begin
            if (n == cswstr_pkg::C_NL) begin
                scan    = cswstr_pkg::MODE_NORMAL;
                prev_ch = pre_cmt;
            end
            return 1'b0;
        end
        if (scan == cswstr_pkg::MODE_BLOCK) begin
            if (c == cswstr_pkg::C_SLASH && p == cswstr_pkg::C_STAR) begin
                scan = cswstr_pkg::MODE_NORMAL;
                if (is_word({1'b0, pre_cmt}) && is_word(n)) begin
                    prev_ch = cswstr_pkg::C_SP[7:0];
                    ch      = cswstr_pkg::C_SP[7:0];
                    return 1'b1;
                end
                prev_ch = pre_cmt;
                return 1'b0;
            end
            prev_ch = c[7:0];
            return 1'b0;
        end
        if (c == cswstr_pkg::C_DQ) begin
            if (in_quote) begin
                if (p != cswstr_pkg::C_BSL) in_quote = 1'b0;
            end else if (!(p == cswstr_pkg::C_SQ && n == cswstr_pkg::C_SQ)) begin
                in_quote = 1'b1;
            end
        end
        if (!in_quote) begin
            if (c == cswstr_pkg::C_SLASH
                && (n == cswstr_pkg::C_SLASH || n == cswstr_pkg::C_STAR)) begin
                pre_cmt = p[7:0];
                scan    = (n == cswstr_pkg::C_SLASH) ? cswstr_pkg::MODE_LINE
                                                     : cswstr_pkg::MODE_BLOCK;
                prev_ch = c[7:0];
                return 1'b0;
            end
            if (is_blank(c) && !(is_word({1'b0, last_out}) && is_word(n))) begin
                if ((c != cswstr_pkg::C_NL && (is_break(p) || is_break(n))) || p == c || c == n)
                    return 1'b0;
            end
        end
        last_out = c[7:0];
        prev_ch  = c[7:0];
        return 1'b1;
    endfunction

    task automatic strip_step(input cswstr_pkg::t_in_item it);
        logic [7:0]            ch;
        cswstr_pkg::t_out_item r;
        if (hold_ok) begin
            if (judge_char({1'b0, hold_ch}, {1'b0, it.in_char}, ch)) begin
                r.out_char     = ch;
                r.char_present = 1'b1;
                r.stream_end   = 1'b0;
                stripped_q.push_back(r);
            end
        end
        if (!it.in_last) begin
            hold_ch = it.in_char;
            hold_ok = 1'b1;
        end else begin
            if (judge_char({1'b0, it.in_char}, cswstr_pkg::C_NONE, ch)) begin
                r.out_char     = ch;
                r.char_present = 1'b1;
            end else begin
                r.out_char     = 8'h00;
                r.char_present = 1'b0;
            end
            r.stream_end = 1'b1;
            stripped_q.push_back(r);
            clear_scan();
        end
    endtask

    task automatic flag_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic compare_stripped(input cswstr_pkg::t_out_item got);
        cswstr_pkg::t_out_item want;
        results_seen++;
        if (got.stream_end) streams_seen++;
        if (got.stream_end && !got.char_present) bare_seen++;
        if (stripped_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result char %02h present %0b end %0b",
                                    got.out_char, got.char_present, got.stream_end));
        end else begin
            want = stripped_q.pop_front();
            if (got.out_char !== want.out_char)
                flag_mismatch($sformatf("out_char %02h, want %02h", got.out_char, want.out_char));
            if (got.char_present !== want.char_present)
                flag_mismatch($sformatf("char_present %0b, want %0b",
                                        got.char_present, want.char_present));
            if (got.stream_end !== want.stream_end)
                flag_mismatch($sformatf("stream_end %0b, want %0b",
                                        got.stream_end, want.stream_end));
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (gap_style == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic put_word_char();
        text_q.push_back(word_chars[$urandom_range(0, 63)]);
    endtask

    task automatic put_blank();
        case ($urandom_range(0, 5))
            0: text_q.push_back(8'h20);
            1: text_q.push_back(8'h09);
            2: text_q.push_back(8'h0A);
            3: text_q.push_back(8'h0D);
            4: text_q.push_back(8'h0B);
            default: text_q.push_back(8'h0C);
        endcase
    endtask

    task automatic put_body(input int unsigned max_len);
        int unsigned len;
        len = $urandom_range(0, max_len);
        for (int unsigned i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
                0, 1: put_word_char();
                2: text_q.push_back(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
                default: text_q.push_back(8'h20);
            endcase
        end
    endtask

    task automatic put_token();
        int unsigned len;
        case ($urandom_range(0, 11))
            0, 1: begin
                len = $urandom_range(1, 6);
                for (int unsigned i = 0; i < len; i++) put_word_char();
            end
            2: begin
                len = $urandom_range(1, 4);
                for (int unsigned i = 0; i < len; i++)
                    text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
            end
            3, 4: begin
                len = $urandom_range(1, 3);
                for (int unsigned i = 0; i < len; i++) put_blank();
            end
            5: text_q.push_back(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
            6: begin
                put_str("//");
                put_body(5);
                text_q.push_back(cswstr_pkg::C_NL[7:0]);
            end
            7: begin
                if ($urandom_range(0, 3) == 0) begin
                    put_str("/*/");
                end else begin
                    put_str("/*");
                    put_body(6);
                    put_str("*/");
                end
            end
            8: begin
                text_q.push_back(cswstr_pkg::C_DQ[7:0]);
                put_body(4);
                if ($urandom_range(0, 2) == 0) put_str("\\\"");
                put_body(3);
                text_q.push_back(cswstr_pkg::C_DQ[7:0]);
            end
            9: put_str("'\"'");
            10: begin
                text_q.push_back(cswstr_pkg::C_SQ[7:0]);
                put_word_char();
                text_q.push_back(cswstr_pkg::C_SQ[7:0]);
            end
            default: begin
                text_q.push_back(cswstr_pkg::C_SLASH[7:0]);
                put_word_char();
            end
        endcase
    endtask

    task automatic send_text(input bit drain_first);
        t_src_item it;
        if (text_q.size() == 0) text_q.push_back(8'h20);
        foreach (text_q[i]) begin
            it.d.in_char = text_q[i];
            it.d.in_last = (i == text_q.size() - 1);
            it.gap       = pick_gap();
            it.drain     = drain_first && (i == 0);
            source_q.push_back(it);
        end
        text_q.delete();
    endtask

    task automatic build_random();
        int unsigned queued;
        int unsigned ntok;
        int unsigned len;
        bit          drain;
        queued = 0;
        while (queued < 1325) begin
            gap_style = ($urandom_range(0, 3) == 0) ? 0 : 1;
            drain     = (queued == 0) || ($urandom_range(0, 40) == 0);
            if ($urandom_range(0, 99) < 85) begin
                ntok = $urandom_range(1, 10);
                for (int unsigned t = 0; t < ntok; t++) put_token();
            end else begin
                case ($urandom_range(0, 3))
                    0, 1: begin
                        len = $urandom_range(1, 8);
                        for (int unsigned i = 0; i < len; i++)
                            text_q.push_back(8'($urandom_range(0, 255)));
                    end
                    2: begin
                        put_str("/*");
                        put_body(5);
                    end
                    default: begin
                        text_q.push_back(($urandom_range(0, 1) == 0) ? cswstr_pkg::C_DQ[7:0]
                                                                     : cswstr_pkg::C_SLASH[7:0]);
                        put_body(5);
                    end
                endcase
            end
            if (text_q.size() == 0) text_q.push_back(8'h20);
            queued += text_q.size();
            send_text(drain);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            clear_scan();
        end else begin
            if (in_valid && !o_in_stall) begin
                strip_step(in_data);
                bytes_sent++;
            end
            if (!in_valid || !o_in_stall) begin
                if (idle_left > 0) begin
                    idle_left--;
                    in_valid <= 1'b0;
                end else if (source_q.size() != 0
                             && !(source_q[0].drain && stripped_q.size() != 0)) begin
                    nxt = source_q.pop_front();
                    if (nxt.gap != 0) begin
                        idle_left = nxt.gap - 1;
                        nxt.gap   = 0;
                        nxt.drain = 1'b0;
                        source_q.push_front(nxt);
                        in_valid <= 1'b0;
                    end else begin
                        in_data  <= nxt.d;
                        in_valid <= 1'b1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) compare_stripped(o_out_data);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (free_left > 0) begin
                free_left--;
                out_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        stall_left = $urandom_range(20, 60);
                        free_left  = 0;
                    end
                    2, 3, 4, 5: begin
                        stall_left = 0;
                        free_left  = $urandom_range(50, 300);
                    end
                    default: begin
                        stall_left = $urandom_range(1, 3);
                        free_left  = $urandom_range(0, 8);
                    end
                endcase
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out <= 1'b1;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // extremes and a lone last byte
        gap_style = 0;
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_text(1'b0);
        put_str(" ");
        send_text(1'b0);
        // slash-star-slash between identifiers
        put_str("a/*/b");
        send_text(1'b0);
        // line comment keeps the newline
        put_str("//c\nx");
        send_text(1'b0);
        // escaped quote inside a string, quote inside single quotes
        put_str("\"\\\"\"");
        send_text(1'b0);
        put_str("'\"'");
        send_text(1'b0);
        // repeated blank between identifiers
        put_str("a  b");
        send_text(1'b0);
        // unclosed comment at stream end
        put_str("/*");
        send_text(1'b0);
        build_random();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out && !(source_q.size() == 0 && !in_valid && stripped_q.size() == 0))
            @(posedge i_clk);
        if (timed_out) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (stripped_q.size() != 0)
                flag_mismatch($sformatf("%0d expected results never arrived", stripped_q.size()));
            $display("Covered %0d source bytes in %0d streams; %0d results checked,",
                     bytes_sent, streams_seen, results_seen);
            $display("%0d bare end markers, %0d mismatches.", bare_seen, errors);
            if (errors == 0) begin
                $display("Simulation PASSED");
            end else begin
                $display("Simulation FAILED");
            end
        end
        $finish;
    end

endmodule
